>>> hw/rtl/rtca_pkg.sv
// Package for the region table carve allocator.
// Holds table sizing, status codes, function codes and the sequencer state type.
// No dependencies.
package rtca_pkg;

    localparam int TableDepth = 64;
    localparam int IdxW       = $clog2(TableDepth);
    localparam int CntW       = $clog2(TableDepth + 1);
    localparam logic [63:0] GuardReset = 64'h1000;

    localparam logic [3:0] UsableReset    = 4'd0;
    localparam logic [3:0] AllocatedReset = 4'd1;

    localparam logic [1:0] CfgUsable    = 2'd0;
    localparam logic [1:0] CfgAllocated = 2'd1;
    localparam logic [1:0] CfgGuard     = 2'd2;

    localparam logic FuncAdd   = 1'b0;
    localparam logic FuncAlloc = 1'b1;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_UNTRACKED = 3'd1,
        ST_LOST      = 3'd2,
        ST_BOTH      = 3'd3,
        ST_BAD       = 3'd4,
        ST_NOSPACE   = 3'd5,
        ST_SKIPPED   = 3'd6,
        ST_FULL      = 3'd7
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIT_CALC,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [63:0] base;
        logic [63:0] length;
        logic [3:0]  kind;
    } entry_t;

endpackage

>>> hw/rtl/rtca_table.sv
// Region table storage: one memory of base/length/kind entries.
// One write port, one registered read port. Depends on rtca_pkg.
module rtca_table (
    input  logic                     clk,
    input  logic                     we,
    input  logic [rtca_pkg::IdxW-1:0] waddr,
    input  rtca_pkg::entry_t         wdata,
    input  logic [rtca_pkg::IdxW-1:0] raddr,
    output rtca_pkg::entry_t         rdata
);

    rtca_pkg::entry_t mem [rtca_pkg::TableDepth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/region_table_carve_allocator_top.sv
// Top level of the region table carve allocator: sequencer and datapath.
// Depends on rtca_pkg and rtca_table.
//
//  channel | signals                                  | direction
//  in      | in_valid/in_stall, func..align_bytes     | into block
//  out     | out_valid/out_stall, status..used_entries| out of block
//  cfg     | cfg_we, cfg_index, cfg_data              | into block
//
// Each table entry scanned passes S_SCAN_RD and S_SCAN_CHK, and each entry moved on
// insertion passes S_SHIFT_RD and S_SHIFT_WR, as the table has a single
// read port. No new item is taken until the result is transferred.
// Reset empties the table count and loads register defaults; entries stay
// undefined until written. The result register holds while out_stall is high.
module region_table_carve_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [63:0] region_base,
    input  logic [63:0] region_length,
    input  logic [3:0]  region_kind,
    input  logic [63:0] alloc_bytes,
    input  logic [63:0] align_bytes,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [63:0] block_address,
    output logic [6:0]  used_entries,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int IW = rtca_pkg::IdxW;
    localparam int CW = rtca_pkg::CntW;
    localparam logic [CW-1:0] Full = CW'(rtca_pkg::TableDepth);

    rtca_pkg::state_t state_reg, state_next;

    logic [3:0]  usable_reg, alloc_code_reg;
    logic [63:0] guard_reg;
    logic [CW-1:0] count_reg, count_next;

    logic        func_reg;
    logic [63:0] a_reg, b_reg;      // add: base/length ; alloc: size/align
    logic [63:0] a_next, b_next;
    logic        func_next;

    logic [CW-1:0] pos_reg, pos_next;   // scan position / insert position
    logic [CW-1:0] j_reg, j_next;       // shift pointer
    logic [63:0] at_reg, at_next, top_reg, top_next, eb_reg, eb_next;
    logic [1:0]  ins_left_reg, ins_left_next;  // inserts still pending
    rtca_pkg::entry_t ins_reg, ins_next;         // entry to insert now
    rtca_pkg::entry_t ins2_reg, ins2_next;       // second insert (above part)
    logic [2:0]  st_reg, st_next;
    logic [63:0] addr_reg, addr_next;

    logic [2:0]  out_st_reg, out_st_next;
    logic [63:0] out_addr_reg, out_addr_next;
    logic [6:0]  out_cnt_reg, out_cnt_next;
    logic        out_v_reg, out_v_next;

    logic        we;
    logic [IW-1:0] waddr, raddr;
    rtca_pkg::entry_t wdata, rdata;

    rtca_table u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_stall      = (state_reg != rtca_pkg::S_IDLE) || out_v_reg;
    assign out_valid     = out_v_reg;
    assign status        = out_st_reg;
    assign block_address = out_addr_reg;
    assign used_entries  = out_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rtca_pkg::S_IDLE;
            count_reg      <= '0;
            out_v_reg      <= 1'b0;
            usable_reg     <= rtca_pkg::UsableReset;
            alloc_code_reg <= rtca_pkg::AllocatedReset;
            guard_reg      <= rtca_pkg::GuardReset;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_v_reg <= out_v_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    rtca_pkg::CfgUsable:    usable_reg     <= cfg_data[3:0];
                    rtca_pkg::CfgAllocated: alloc_code_reg <= cfg_data[3:0];
                    rtca_pkg::CfgGuard:     guard_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        pos_reg      <= pos_next;
        j_reg        <= j_next;
        at_reg       <= at_next;
        top_reg      <= top_next;
        eb_reg       <= eb_next;
        ins_left_reg <= ins_left_next;
        ins_reg      <= ins_next;
        ins2_reg     <= ins2_next;
        st_reg       <= st_next;
        addr_reg     <= addr_next;
        out_st_reg   <= out_st_next;
        out_addr_reg <= out_addr_next;
        out_cnt_reg  <= out_cnt_next;
    end

    // scan-check terms
    logic        kind_ok, len_ok;
    logic [63:0] top_c, at_c;
    assign kind_ok = (rdata.kind == usable_reg);
    assign len_ok  = (rdata.length >= a_reg);
    assign top_c   = rdata.base + rdata.length;
    assign at_c    = (top_c - a_reg) & ~(b_reg - 64'd1);

    logic [63:0] end_c, below_c, above_c;
    assign end_c   = at_reg + a_reg;
    assign below_c = at_reg - eb_reg;
    assign above_c = top_reg - end_c;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        out_v_next    = out_v_reg;
        func_next     = func_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        pos_next      = pos_reg;
        j_next        = j_reg;
        at_next       = at_reg;
        top_next      = top_reg;
        eb_next       = eb_reg;
        ins_left_next = ins_left_reg;
        ins_next      = ins_reg;
        ins2_next     = ins2_reg;
        st_next       = st_reg;
        addr_next     = addr_reg;
        out_st_next   = out_st_reg;
        out_addr_next = out_addr_reg;
        out_cnt_next  = out_cnt_reg;
        we    = 1'b0;
        waddr = pos_reg[IW-1:0];
        wdata = ins_reg;
        raddr = pos_reg[IW-1:0];

        if (out_v_reg && !out_stall)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            rtca_pkg::S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    func_next = func;
                    pos_next  = '0;
                    addr_next = '0;
                    st_next   = rtca_pkg::ST_DONE;
                    if (func == rtca_pkg::FuncAdd)
                    begin
                        a_next = region_base;
                        b_next = region_length;
                        ins_next = '{base: region_base, length: region_length,
                                     kind: region_kind};
                        ins_left_next = 2'd1;
                        if (region_length == 64'd0)
                        begin
                            st_next    = rtca_pkg::ST_SKIPPED;
                            state_next = rtca_pkg::S_OUT;
                        end
                        else if (count_reg >= Full)
                        begin
                            st_next    = rtca_pkg::ST_FULL;
                            state_next = rtca_pkg::S_OUT;
                        end
                        else
                        begin
                            state_next = rtca_pkg::S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        a_next = alloc_bytes;
                        b_next = align_bytes;
                        if (alloc_bytes == 64'd0 || align_bytes == 64'd0 ||
                            ((align_bytes & (align_bytes - 64'd1)) != 64'd0))
                        begin
                            st_next    = rtca_pkg::ST_BAD;
                            state_next = rtca_pkg::S_OUT;
                        end
                        else
                        begin
                            state_next = rtca_pkg::S_SCAN_RD;
                        end
                    end
                end
            end

            rtca_pkg::S_SCAN_RD:
            begin
                if (pos_reg >= count_reg)
                begin
                    if (func_reg == rtca_pkg::FuncAdd)
                    begin
                        j_next     = count_reg;
                        state_next = rtca_pkg::S_SHIFT_RD;
                    end
                    else
                    begin
                        st_next    = rtca_pkg::ST_NOSPACE;
                        state_next = rtca_pkg::S_OUT;
                    end
                end
                else
                begin
                    state_next = rtca_pkg::S_SCAN_CHK;
                end
            end

            rtca_pkg::S_SCAN_CHK:
            begin
                if (func_reg == rtca_pkg::FuncAdd)
                begin
                    if (rdata.base <= a_reg)
                    begin
                        pos_next   = pos_reg + CW'(1);
                        state_next = rtca_pkg::S_SCAN_RD;
                    end
                    else
                    begin
                        j_next     = count_reg;
                        state_next = rtca_pkg::S_SHIFT_RD;
                    end
                end
                else if (kind_ok && len_ok && (at_c >= rdata.base) &&
                         (at_c >= guard_reg))
                begin
                    at_next    = at_c;
                    top_next   = top_c;
                    eb_next    = rdata.base;
                    state_next = rtca_pkg::S_FIT_CALC;
                end
                else
                begin
                    pos_next   = pos_reg + CW'(1);
                    state_next = rtca_pkg::S_SCAN_RD;
                end
            end

            rtca_pkg::S_FIT_CALC:
            begin
                addr_next = at_reg;
                we        = 1'b1;
                waddr     = pos_reg[IW-1:0];
                pos_next  = pos_reg + CW'(1);
                j_next    = count_reg;
                if (below_c == 64'd0 && above_c == 64'd0)
                begin
                    wdata = '{base: eb_reg, length: top_reg - eb_reg,
                              kind: alloc_code_reg};
                    state_next = rtca_pkg::S_OUT;
                end
                else if (above_c == 64'd0)
                begin
                    wdata = '{base: eb_reg, length: below_c, kind: usable_reg};
                    ins_next = '{base: at_reg, length: a_reg, kind: alloc_code_reg};
                    ins_left_next = 2'd1;
                    if (count_reg >= Full)
                    begin
                        st_next    = rtca_pkg::ST_UNTRACKED;
                        state_next = rtca_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = rtca_pkg::S_SHIFT_RD;
                    end
                end
                else if (below_c == 64'd0)
                begin
                    wdata = '{base: at_reg, length: a_reg, kind: alloc_code_reg};
                    ins_next = '{base: end_c, length: above_c, kind: usable_reg};
                    ins_left_next = 2'd1;
                    if (count_reg >= Full)
                    begin
                        st_next    = rtca_pkg::ST_LOST;
                        state_next = rtca_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = rtca_pkg::S_SHIFT_RD;
                    end
                end
                else
                begin
                    wdata = '{base: eb_reg, length: below_c, kind: usable_reg};
                    ins_next  = '{base: at_reg, length: a_reg, kind: alloc_code_reg};
                    ins2_next = '{base: end_c, length: above_c, kind: usable_reg};
                    ins_left_next = 2'd2;
                    if (count_reg >= Full)
                    begin
                        st_next    = rtca_pkg::ST_BOTH;
                        state_next = rtca_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = rtca_pkg::S_SHIFT_RD;
                    end
                end
            end

            // move entries [pos, count) up by one, top first
            rtca_pkg::S_SHIFT_RD:
            begin
                if (j_reg > pos_reg)
                begin
                    raddr      = IW'(j_reg - CW'(1));
                    state_next = rtca_pkg::S_SHIFT_WR;
                end
                else
                begin
                    state_next = rtca_pkg::S_INS;
                end
            end

            rtca_pkg::S_SHIFT_WR:
            begin
                we         = 1'b1;
                waddr      = j_reg[IW-1:0];
                wdata      = rdata;
                j_next     = j_reg - CW'(1);
                state_next = rtca_pkg::S_SHIFT_RD;
            end

            rtca_pkg::S_INS:
            begin
                we         = 1'b1;
                waddr      = pos_reg[IW-1:0];
                wdata      = ins_reg;
                count_next = count_reg + CW'(1);
                if (ins_left_reg == 2'd2)
                begin
                    ins_left_next = 2'd1;
                    ins_next      = ins2_reg;
                    pos_next      = pos_reg + CW'(1);
                    j_next        = count_reg + CW'(1);
                    if (count_reg + CW'(1) >= Full)
                    begin
                        st_next    = rtca_pkg::ST_LOST;
                        state_next = rtca_pkg::S_OUT;
                    end
                    else
                    begin
                        state_next = rtca_pkg::S_SHIFT_RD;
                    end
                end
                else
                begin
                    state_next = rtca_pkg::S_OUT;
                end
            end

            rtca_pkg::S_OUT:
            begin
                if (!out_v_reg)
                begin
                    out_v_next    = 1'b1;
                    out_st_next   = st_reg;
                    out_addr_next = (st_reg <= rtca_pkg::ST_BOTH) ? addr_reg : 64'd0;
                    out_cnt_next  = 7'(count_reg);
                    state_next    = rtca_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = rtca_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Testbench for region_table_carve_allocator_top: directed table plus random
// add/allocate traffic checked against an in-bench region table predictor.
// Depends on rtca_pkg and the allocator RTL.
module tb;

    localparam int Depth = rtca_pkg::TableDepth;
    localparam int CycleLimit = 2000000;

    typedef struct {
        logic        fn;
        logic [63:0] rbase;
        logic [63:0] rlen;
        logic [3:0]  rkind;
        logic [63:0] asize;
        logic [63:0] aalign;
    } req_t;

    typedef struct {
        logic [2:0]  st;
        logic [63:0] addr;
        logic [6:0]  used;
    } resp_t;

    typedef struct {
        req_t  rq;
        bit    has_exp;
        resp_t ex;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        func;
    logic [63:0] region_base;
    logic [63:0] region_length;
    logic [3:0]  region_kind;
    logic [63:0] alloc_bytes;
    logic [63:0] align_bytes;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [63:0] block_address;
    logic [6:0]  used_entries;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    region_table_carve_allocator_top dut (.*);

    // predictor copy of the table and registers
    logic [63:0] tbl_base [Depth];
    logic [63:0] tbl_len  [Depth];
    logic [3:0]  tbl_kind [Depth];
    int          tbl_cnt;
    logic [3:0]  m_usable;
    logic [3:0]  m_alloc;
    logic [63:0] m_guard;

    resp_t pending_results[$];
    int    errors;
    int    cycles;
    int    send_idle_pct;
    int    stall_pct;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAIL region_table_carve_allocator_top");
            $finish;
        end
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    endtask

    function automatic bit insert_entry(int pos, logic [63:0] b, logic [63:0] len,
                                        logic [3:0] k);
        if (tbl_cnt >= Depth || pos > tbl_cnt)
            return 0;
        for (int j = tbl_cnt; j > pos; j--)
        begin
            tbl_base[j] = tbl_base[j-1];
            tbl_len[j]  = tbl_len[j-1];
            tbl_kind[j] = tbl_kind[j-1];
        end
        tbl_base[pos] = b;
        tbl_len[pos]  = len;
        tbl_kind[pos] = k;
        tbl_cnt++;
        return 1;
    endfunction

    function automatic resp_t carve_predict(req_t rq);
        resp_t r;
        rtca_pkg::status_t st;
        int pos;
        logic [63:0] b, top, at, below, above;
        r.addr = '0;
        st = rtca_pkg::ST_NOSPACE;
        if (rq.fn == rtca_pkg::FuncAdd)
        begin
            if (rq.rlen == 0)
                st = rtca_pkg::ST_SKIPPED;
            else if (tbl_cnt >= Depth)
                st = rtca_pkg::ST_FULL;
            else
            begin
                pos = 0;
                while (pos < tbl_cnt && tbl_base[pos] <= rq.rbase)
                    pos++;
                void'(insert_entry(pos, rq.rbase, rq.rlen, rq.rkind));
                st = rtca_pkg::ST_DONE;
            end
        end
        else if (rq.asize == 0 || rq.aalign == 0 || (rq.aalign & (rq.aalign - 1)) != 0)
            st = rtca_pkg::ST_BAD;
        else
        begin
            for (int i = 0; i < tbl_cnt; i++)
            begin
                if (tbl_kind[i] != m_usable || tbl_len[i] < rq.asize)
                    continue;
                b = tbl_base[i];
                top = b + tbl_len[i];
                at = (top - rq.asize) & ~(rq.aalign - 1);
                if (at < b || at < m_guard)
                    continue;
                r.addr = at;
                below = at - b;
                above = top - (at + rq.asize);
                if (below == 0 && above == 0)
                begin
                    tbl_kind[i] = m_alloc;
                    st = rtca_pkg::ST_DONE;
                end
                else if (above == 0)
                begin
                    tbl_len[i] = below;
                    st = insert_entry(i + 1, at, rq.asize, m_alloc) ?
                         rtca_pkg::ST_DONE : rtca_pkg::ST_UNTRACKED;
                end
                else if (below == 0)
                begin
                    tbl_base[i] = at;
                    tbl_len[i]  = rq.asize;
                    tbl_kind[i] = m_alloc;
                    st = insert_entry(i + 1, at + rq.asize, above, m_usable) ?
                         rtca_pkg::ST_DONE : rtca_pkg::ST_LOST;
                end
                else
                begin
                    tbl_len[i] = below;
                    if (!insert_entry(i + 1, at, rq.asize, m_alloc))
                        st = rtca_pkg::ST_BOTH;
                    else
                        st = insert_entry(i + 2, at + rq.asize, above, m_usable) ?
                             rtca_pkg::ST_DONE : rtca_pkg::ST_LOST;
                end
                break;
            end
        end
        r.st = st;
        if (st > rtca_pkg::ST_BOTH)
            r.addr = '0;
        r.used = tbl_cnt[6:0];
        return r;
    endfunction

    // result side: random stall, compare on transfer
    always @(posedge clk)
    begin
        resp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report("unexpected result", {61'd0, status}, 64'd0);
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                    report("status", status, e.st);
                if (block_address !== e.addr)
                    report("block_address", block_address, e.addr);
                if (used_entries !== e.used)
                    report("used_entries", used_entries, e.used);
            end
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // leaves in_valid high on return; the next send drives it again, or drain drops it
    task automatic send(req_t rq, bit has_exp, resp_t ex);
        resp_t p;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            func     <= 1'($urandom_range(1));
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge clk);
        end
        in_valid      <= 1'b1;
        func          <= rq.fn;
        region_base   <= rq.rbase;
        region_length <= rq.rlen;
        region_kind   <= rq.rkind;
        alloc_bytes   <= rq.asize;
        align_bytes   <= rq.aalign;
        p = carve_predict(rq);
        if (has_exp && (p.st !== ex.st || p.addr !== ex.addr || p.used !== ex.used))
            $display("note: table row disagrees with predictor");
        pending_results.push_back(has_exp ? ex : p);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            rtca_pkg::CfgUsable:    m_usable = val[3:0];
            rtca_pkg::CfgAllocated: m_alloc  = val[3:0];
            default:                m_guard  = val;
        endcase
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic req_t mk(logic fn, logic [63:0] b, logic [63:0] l, logic [3:0] k,
                                logic [63:0] s, logic [63:0] a);
        req_t r;
        r.fn = fn; r.rbase = b; r.rlen = l; r.rkind = k; r.asize = s; r.aalign = a;
        return r;
    endfunction

    function automatic resp_t mr(rtca_pkg::status_t st, logic [63:0] a, int u);
        resp_t r;
        r.st = st; r.addr = a; r.used = u[6:0];
        return r;
    endfunction

    function automatic row_t row(req_t rq, bit h, resp_t ex);
        row_t r;
        r.rq = rq; r.has_exp = h; r.ex = ex;
        return r;
    endfunction

    // random request; mostly well-formed with small sizes, some noise
    function automatic req_t rand_req();
        req_t r;
        int pick;
        r = mk(1'($urandom_range(1)), rand64(), rand64(), 4'($urandom_range(15)),
               rand64(), rand64());
        pick = $urandom_range(99);
        if (r.fn == rtca_pkg::FuncAdd)
        begin
            if (pick < 80)
            begin
                r.rbase = 64'(($urandom_range(255)) << 12);
                r.rlen  = 64'($urandom_range(1, 64)) << $urandom_range(4, 12);
                r.rkind = ($urandom_range(3) != 0) ? m_usable : 4'($urandom_range(15));
            end
            else if (pick < 85)
                r.rlen = '0;
            else if (pick < 90)
                r.rbase = ~64'(0) - 64'($urandom_range(4095));
        end
        else
        begin
            if (pick < 80)
            begin
                r.asize  = 64'($urandom_range(1, 4096));
                r.aalign = 64'(1) << $urandom_range(0, 12);
            end
            else if (pick < 85)
                r.asize = '0;
            else if (pick < 90)
                r.aalign = 64'(1) << $urandom_range(0, 63);
        end
        return r;
    endfunction

    initial
    begin
        row_t  rows[$];
        resp_t none;
        none = mr(rtca_pkg::ST_DONE, 0, 0);
        errors = 0;
        send_idle_pct = 0; stall_pct = 0;
        rst_n = 1'b0; in_valid = 1'b0; out_stall = 1'b0;
        func = 1'b0; region_base = '0; region_length = '0; region_kind = '0;
        alloc_bytes = '0; align_bytes = '0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        tbl_cnt = 0;
        m_usable = rtca_pkg::UsableReset;
        m_alloc  = rtca_pkg::AllocatedReset;
        m_guard  = rtca_pkg::GuardReset;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed rows at reset register values
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 16, 16), 1,
                           mr(rtca_pkg::ST_NOSPACE, 0, 0)));
        rows.push_back(row(mk(rtca_pkg::FuncAdd, 64'h5000, 0, 0, 0, 0), 1,
                           mr(rtca_pkg::ST_SKIPPED, 0, 0)));
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 0, 16), 1,
                           mr(rtca_pkg::ST_BAD, 0, 0)));
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 16, 0), 1,
                           mr(rtca_pkg::ST_BAD, 0, 0)));
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 16, 24), 1,
                           mr(rtca_pkg::ST_BAD, 0, 0)));
        rows.push_back(row(mk(rtca_pkg::FuncAdd, 64'h10000, 64'h1000, 0, '1, '1), 1,
                           mr(rtca_pkg::ST_DONE, 0, 1)));
        // exact fit
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, '1, '1, 4'hf, 64'h1000, 64'h1000), 1,
                           mr(rtca_pkg::ST_DONE, 64'h10000, 1)));
        rows.push_back(row(mk(rtca_pkg::FuncAdd, 64'h20000, 64'h10000, 0, 0, 0), 0, none));
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 64'h100, 64'h1), 0, none));
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 64'h100, 64'h10000), 0, none));
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 64'h30, 64'h1000), 0, none));
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, '1, 64'h1), 0, none));
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 16, 64'h8000_0000_0000_0000),
                           0, none));
        // wrapping region near the top of address space
        rows.push_back(row(mk(rtca_pkg::FuncAdd, 64'hffff_ffff_ffff_f000, 64'h2000, 0, 0, 0),
                           0, none));
        rows.push_back(row(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 64'h800, 64'h800), 0, none));
        rows.push_back(row(mk(rtca_pkg::FuncAdd, '1, '1, 4'hf, 0, 0), 0, none));
        rows.push_back(row(mk(rtca_pkg::FuncAdd, 0, 64'h4000, 0, 0, 0), 0, none));
        rows.push_back(row(mk(rtca_pkg::FuncAdd, 64'h20000, 64'h800, 0, 0, 0), 0, none));
        foreach (rows[i])
            send(rows[i].rq, rows[i].has_exp, rows[i].ex);
        drain();

        // guard of zero, other codes
        write_reg(rtca_pkg::CfgGuard, 0);
        write_reg(rtca_pkg::CfgUsable, 4'hf);
        write_reg(rtca_pkg::CfgAllocated, 4'h0);
        send(mk(rtca_pkg::FuncAdd, 0, 64'h100, 4'hf, 0, 0), 0, none);
        send(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 64'h100, 64'h100), 0, none);
        // fill the table so splits hit the full cases
        repeat (70)
            send(mk(rtca_pkg::FuncAdd, 64'($urandom_range(255)) << 16, 64'h3000, 4'hf, 0, 0),
                 0, none);
        send(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 64'h1000, 64'h1000), 0, none);
        send(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 64'h800, 64'h1000), 0, none);
        send(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 64'h1000, 64'h2000), 0, none);
        send(mk(rtca_pkg::FuncAlloc, 0, 0, 0, 64'h2000, 64'h1), 0, none);
        drain();

        // random phases; the table is not emptied again by a re-reset,
        // so vary guard and codes per phase; adds fail once the table is full
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 82; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 82; end
                3: begin send_idle_pct = 35; stall_pct = 35; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            drain();
            write_reg(rtca_pkg::CfgUsable, 4'($urandom_range(15)));
            write_reg(rtca_pkg::CfgAllocated, 4'($urandom_range(15)));
            write_reg(rtca_pkg::CfgGuard, (ph == 4) ? '1 : 64'($urandom_range(3)) << 12);
            for (int n = 0; n < 300; n++)
            begin
                send(rand_req(), 0, none);
                if (n == 150)
                begin
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(negedge clk);
                end
            end
        end
        send_idle_pct = 0; stall_pct = 0;
        drain();
        if (errors == 0)
            $display("PASS region_table_carve_allocator_top");
        else
            $display("FAIL region_table_carve_allocator_top");
        $finish;
    end
endmodule
